// ===== rtl/core/ppd_pkg.sv =====
`default_nettype none

package ppd_pkg;

   // Sequencer states of the root search.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TRY,
      ST_WAIT,
      ST_REPORT
   } state_type;

   // Outcome of one power test: done marks the cycle in which le and eq are valid.
   typedef struct packed {
      logic done;
      logic le;
      logic eq;
   } pow_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/ppd_pow_unit.sv =====
`default_nettype none

module ppd_pow_unit #(
   parameter int NUM_W  = 32,
   parameter int ROOT_W = 16,
   parameter int EXP_W  = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [ROOT_W-1:0]     cand,
   input  wire logic [EXP_W-1:0]      expo,
   input  wire logic [NUM_W-1:0]      number,
   output ppd_pkg::pow_result_type    result
);

   localparam int AccW = NUM_W + ROOT_W;

   logic              active_ff, active_in;
   logic [AccW-1:0]   acc_ff, acc_in;
   logic [ROOT_W-1:0] cand_ff, cand_in;
   logic [EXP_W-1:0]  cnt_ff, cnt_in;

   logic [AccW-1:0]   number_ext;
   logic [AccW-1:0]   prod;
   logic              over;

   assign number_ext = AccW'(number);

   // While the partial power stays at or below the number it fits in NUM_W bits,
   // so only those bits feed the multiplier. The compare runs beside it.
   assign prod = AccW'(acc_ff[NUM_W-1:0]) * AccW'(cand_ff);
   assign over = acc_ff > number_ext;

   always_comb begin
      result.done = active_ff && (over || (cnt_ff == '0));
      result.le   = !over;
      result.eq   = (acc_ff == number_ext);
   end

   always_comb begin
      active_in = active_ff;
      acc_in    = acc_ff;
      cand_in   = cand_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         active_in = 1'b1;
         acc_in    = AccW'(cand);
         cand_in   = cand;
         cnt_in    = expo - 1'b1;
      end else if (result.done) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         acc_in = prod;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      cand_ff <= cand_in;
      cnt_ff  <= cnt_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/perfect_power_detector.sv =====
// Perfect power detector.
// A beat on the request side is taken at a rising edge where start is high and
// busy is low; req_number is the value to test (low NUMBER_WIDTH bits kept).
// busy stays high from that edge until the result has been shown, so one
// number is worked on at a time.
// Exactly one result beat follows each request: rsp_valid is high for one
// cycle with rsp_is_perfect, rsp_base and rsp_exponent. A perfect power gives
// the smallest base and its exponent (at least 2); anything else gives zeros.
// The receiver has no way to stall; the result is there for that one cycle.
// Exponents are tried from NUMBER_WIDTH-1 down to 2. For each, the integer
// root is built one bit per try from the top bit the exponent allows, and each
// try raises the candidate to the exponent on a single shared multiplier, one
// product per cycle, stopping early once the power passes the number.
// Numbers below 4 skip the search and get their result beat in the cycle
// after the request beat. The next request beat can be taken in the cycle
// after the result beat.
// Reset returns the sequencer to idle and drops any search in progress.
`default_nettype none

module perfect_power_detector #(
   parameter int NUMBER_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_number,
   output logic             rsp_valid,
   output logic             rsp_is_perfect,
   output logic [15:0]      rsp_base,
   output logic [4:0]       rsp_exponent
);

   localparam int NW = (NUMBER_WIDTH < 32) ? NUMBER_WIDTH : 32;
   localparam int RW = (NW + 1) / 2;
   localparam int EW = $clog2(NUMBER_WIDTH);
   localparam int BW = $clog2(RW);

   ppd_pkg::state_type state_ff, state_in;

   logic [NW-1:0]  n_ff;
   logic [EW-1:0]  exp_ff;
   logic [BW-1:0]  bit_ff;
   logic [RW-1:0]  root_ff;
   logic           exact_ff;
   logic           found_ff;
   logic [15:0]    base_ff;
   logic [4:0]     expo_ff;

   logic [BW-1:0]  top_bit_tab [NUMBER_WIDTH];
   logic [NW-1:0]  n_in;
   logic           accept;
   logic           small_n;
   logic [RW-1:0]  cand;
   logic [RW-1:0]  root_upd;
   logic           exact_upd;
   logic           last_bit;
   logic           last_exp;
   logic [EW-1:0]  exp_next;
   logic           pow_start;

   ppd_pkg::pow_result_type pow_res;

   // Highest root bit worth trying per exponent: a root of an NW-bit number
   // for exponent e has at most ceil(NW/e) bits.
   for (genvar g = 0; g < NUMBER_WIDTH; g++) begin : g_top
      if (g < 2) begin : g_unused
         assign top_bit_tab[g] = '0;
      end else begin : g_root
         localparam int RootBits = (NW + g - 1) / g;
         localparam int TopBit = (RootBits < RW) ? RootBits - 1 : RW - 1;
         assign top_bit_tab[g] = BW'(TopBit);
      end
   end

   assign n_in      = req_number[NW-1:0];
   assign accept    = start && !busy;
   assign small_n   = n_in < NW'(4);
   assign cand      = root_ff | (RW'(1) << bit_ff);
   assign root_upd  = pow_res.le ? cand : root_ff;
   assign exact_upd = pow_res.le ? pow_res.eq : exact_ff;
   assign last_bit  = (bit_ff == '0);
   assign last_exp  = (exp_ff == EW'(2));
   assign exp_next  = exp_ff - 1'b1;

   ppd_pow_unit #(
      .NUM_W  (NW),
      .ROOT_W (RW),
      .EXP_W  (EW)
   ) u_pow (
      .clock  (clock),
      .reset  (reset),
      .start  (pow_start),
      .cand   (cand),
      .expo   (exp_ff),
      .number (n_ff),
      .result (pow_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = small_n ? ppd_pkg::ST_REPORT : ppd_pkg::ST_TRY;
            end
         end
         ppd_pkg::ST_TRY: begin
            state_in = ppd_pkg::ST_WAIT;
         end
         ppd_pkg::ST_WAIT: begin
            if (pow_res.done) begin
               if (!last_bit) begin
                  state_in = ppd_pkg::ST_TRY;
               end else if (exact_upd || last_exp) begin
                  state_in = ppd_pkg::ST_REPORT;
               end else begin
                  state_in = ppd_pkg::ST_TRY;
               end
            end
         end
         ppd_pkg::ST_REPORT: begin
            state_in = ppd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ppd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = (state_ff != ppd_pkg::ST_IDLE);
      pow_start = (state_ff == ppd_pkg::ST_TRY);
      rsp_valid = (state_ff == ppd_pkg::ST_REPORT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ppd_pkg::ST_IDLE && accept) begin
         n_ff     <= n_in;
         exp_ff   <= EW'(NUMBER_WIDTH - 1);
         bit_ff   <= top_bit_tab[EW'(NUMBER_WIDTH - 1)];
         root_ff  <= '0;
         exact_ff <= 1'b0;
         found_ff <= 1'b0;
         base_ff  <= '0;
         expo_ff  <= '0;
      end else if (state_ff == ppd_pkg::ST_WAIT && pow_res.done) begin
         if (!last_bit) begin
            root_ff  <= root_upd;
            exact_ff <= exact_upd;
            bit_ff   <= bit_ff - 1'b1;
         end else if (exact_upd) begin
            // The largest exponent with an exact root gives the smallest base.
            root_ff  <= root_upd;
            exact_ff <= exact_upd;
            found_ff <= 1'b1;
            base_ff  <= 16'(root_upd);
            expo_ff  <= 5'(exp_ff);
         end else if (!last_exp) begin
            exp_ff   <= exp_next;
            bit_ff   <= top_bit_tab[exp_next];
            root_ff  <= '0;
            exact_ff <= 1'b0;
         end
      end
   end

   assign rsp_is_perfect = found_ff;
   assign rsp_base       = base_ff;
   assign rsp_exponent   = expo_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after a request beat");

   a_report_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after its result beat");

   a_perfect_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_perfect |-> rsp_exponent != 5'd0 && rsp_exponent != 5'd1
         && rsp_base != 16'd0 && rsp_base != 16'd1)
      else $error("perfect result with base or exponent below two");

   a_not_perfect_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_perfect |-> rsp_base == 16'd0 && rsp_exponent == 5'd0)
      else $error("non-perfect result carries a base or exponent");

   a_pow_quiet: assert property (@(posedge clock) disable iff (reset)
      pow_res.done |-> state_ff == ppd_pkg::ST_WAIT)
      else $error("power unit finished outside the wait state");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_perfect_power_detector.sv =====
module tb_perfect_power_detector;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 265;
   localparam int QUIET_TAIL    = 40;
   localparam int DRAIN_CYCLES  = 1500;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam int TOP_EXPONENT  = 31;

   typedef struct {
      logic [31:0] number;
      logic        is_perfect;
      logic [15:0] base;
      logic [4:0]  exponent;
   } power_answer_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_number = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_is_perfect;
   logic [15:0] rsp_base;
   logic [4:0]  rsp_exponent;

   logic [31:0]   pending_numbers[$];
   power_answer_t awaited_answers[$];

   int total_numbers = 0;
   int accepted_numbers = 0;
   int answers_checked = 0;
   int perfect_answers = 0;
   int mismatch_count = 0;
   int idle_left = 0;
   int cycle_count = 0;

   perfect_power_detector dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_is_perfect (rsp_is_perfect),
      .rsp_base       (rsp_base),
      .rsp_exponent   (rsp_exponent)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // True when b^e stays at or below n; partial products never exceed 2^48.
   function automatic bit power_fits(longint unsigned b, int e, longint unsigned n);
      longint unsigned acc;
      acc = 1;
      for (int i = 0; i < e; i++) begin
         acc = acc * b;
         if (acc > n) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic longint unsigned raise(longint unsigned b, int e);
      longint unsigned acc;
      acc = 1;
      for (int i = 0; i < e; i++) acc = acc * b;
      return acc;
   endfunction

   // Largest r with r^e <= n; e is at least 2, so r never reaches 65536.
   function automatic longint unsigned floor_root(longint unsigned n, int e);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 65536;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (power_fits(mid, e, n)) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   // The highest exponent with an exact root gives the smallest base.
   function automatic power_answer_t predict_power(logic [31:0] number);
      power_answer_t answer;
      longint unsigned n;
      longint unsigned r;
      bit found;
      answer.number = number;
      answer.is_perfect = 1'b0;
      answer.base = '0;
      answer.exponent = '0;
      n = number;
      found = 1'b0;
      if (n >= 4) begin
         for (int e = TOP_EXPONENT; e >= 2 && !found; e--) begin
            r = floor_root(n, e);
            if (r >= 2 && raise(r, e) == n) begin
               found = 1'b1;
               answer.is_perfect = 1'b1;
               answer.base = r[15:0];
               answer.exponent = e[4:0];
            end
         end
      end
      return answer;
   endfunction

   function automatic logic [31:0] random_power();
      int e;
      int unsigned top_base;
      longint unsigned value;
      e = $urandom_range(TOP_EXPONENT, 2);
      top_base = int'(floor_root(64'hFFFF_FFFF, e));
      value = raise($urandom_range(top_base, 2), e);
      return value[31:0];
   endfunction

   // Driver: start is held until a beat is taken, then the next number follows
   // unless a burst of idle cycles is drawn.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_number <= '0;
         idle_left <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            awaited_answers.push_back(predict_power(req_number));
            accepted_numbers++;
         end
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (pending_numbers.size() == 0) begin
            start <= 1'b0;
         end else if (pending_numbers.size() > QUIET_TAIL && $urandom_range(5, 0) == 0) begin
            idle_left <= $urandom_range(14, 1) - 1;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_number <= pending_numbers.pop_front();
         end
      end
   end

   // Monitor: each strobed result is compared with the oldest awaited answer.
   always @(posedge clock) begin
      power_answer_t want;
      if (!reset && rsp_valid) begin
         if (awaited_answers.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected result beat: perfect=%0d base=%0d exponent=%0d",
                        rsp_is_perfect, rsp_base, rsp_exponent);
            mismatch_count++;
         end else begin
            want = awaited_answers.pop_front();
            answers_checked++;
            if (rsp_is_perfect === 1'b1) perfect_answers++;
            if (rsp_is_perfect !== want.is_perfect || rsp_base !== want.base ||
                rsp_exponent !== want.exponent) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("mismatch for %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           want.number, want.is_perfect, want.base, want.exponent,
                           rsp_is_perfect, rsp_base, rsp_exponent);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers still awaited",
                  cycle_count, awaited_answers.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [31:0] directed_numbers[] = '{
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd36, 32'd64,
         32'd1024, 32'd65536, 32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF,
         32'hFFFE_0001, 32'hFFFE_0000, 32'd3486784401, 32'd2176782336,
         32'd1977326743, 32'h8000_0001, 32'd4294967291, 32'd2147488281,
         32'd1073741823, 32'd15};
      logic [31:0] value;

      foreach (directed_numbers[i]) pending_numbers.push_back(directed_numbers[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(99, 0)) inside
            [0:49]:  value = random_power();
            [50:64]: value = ($urandom_range(1, 0) == 1) ? random_power() + 32'd1
                                                         : random_power() - 32'd1;
            [65:84]: value = $urandom();
            default: value = $urandom() >> $urandom_range(31, 0);
         endcase
         pending_numbers.push_back(value);
      end
      total_numbers = pending_numbers.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_numbers < total_numbers) @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d of %0d numbers (%0d perfect powers) in %0d cycles",
               answers_checked, total_numbers, perfect_answers, cycle_count);
      $display("mismatches or stray results: %0d", mismatch_count);
      if (mismatch_count == 0 && awaited_answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
